@@ design/slm_pkg.sv @@
`timescale 1ns / 1ps

package slm_pkg;

    // fixed field widths
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int SUM_W    = POS_W + 1;
    localparam int ACTION_W = 2;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    // request kinds carried on s_tuser
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_A = 2'd0,
        ACT_PUSH_B = 2'd1,
        ACT_MERGE  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_EMPTY
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic push_a;
        logic push_b;
        logic step;
        logic emit_empty;
    } slm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic last_step;
        logic lists_empty;
    } slm_status_t;

endpackage

@@ design/slm_ctrl.sv @@
`timescale 1ns / 1ps

module slm_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [slm_pkg::ACTION_W-1:0] action,
    input  slm_pkg::slm_status_t        status,
    output slm_pkg::slm_cmd_t           cmd
);
    import slm_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    action_t act;
    logic    accept;

    assign act    = action_t'(action);
    assign accept = s_tvalid && s_tready;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && act == ACT_MERGE) begin
                    state_next = status.lists_empty ? ST_EMPTY : ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (status.out_free && status.last_step) begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs, ready is always high while idle
    always_comb begin
        s_tready       = 1'b0;
        cmd.push_a     = 1'b0;
        cmd.push_b     = 1'b0;
        cmd.step       = 1'b0;
        cmd.emit_empty = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.push_a = s_tvalid && act == ACT_PUSH_A;
                cmd.push_b = s_tvalid && act == ACT_PUSH_B;
            end
            ST_MERGE: begin
                cmd.step = status.out_free;
            end
            ST_EMPTY: begin
                cmd.emit_empty = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

@@ design/slm_datapath.sv @@
`timescale 1ns / 1ps

module slm_datapath #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [slm_pkg::VALUE_W-1:0]  value,
    input  slm_pkg::slm_cmd_t            cmd,
    output slm_pkg::slm_status_t         status,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [slm_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast,
    output logic [0:0]                   m_tuser
);
    import slm_pkg::*;

    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    logic [VALUE_W-1:0] mem_a [LIST_DEPTH];
    logic [VALUE_W-1:0] mem_b [LIST_DEPTH];

    logic [CNT_W-1:0]   a_cnt_reg, a_cnt_next;
    logic [CNT_W-1:0]   b_cnt_reg, b_cnt_next;
    logic [ADDR_W-1:0]  a_rd_addr, b_rd_addr;
    logic [VALUE_W-1:0] a_head_reg, b_head_reg;
    logic [SUM_W-1:0]   sum_m1;
    logic               take_a;
    logic               a_full, b_full;

    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   out_pos_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;
    logic               out_empty_reg;

    assign a_full = (a_cnt_reg == DEPTH_C);
    assign b_full = (b_cnt_reg == DEPTH_C);

    // merge from the back: larger head wins, b wins ties
    assign take_a = (b_cnt_reg == '0) ||
                    ((a_cnt_reg != '0) && ($signed(a_head_reg) > $signed(b_head_reg)));

    assign sum_m1 = SUM_W'(a_cnt_reg) + SUM_W'(b_cnt_reg) - SUM_W'(1);

    // list counts
    always_comb begin
        a_cnt_next = a_cnt_reg;
        b_cnt_next = b_cnt_reg;
        if (cmd.push_a && !a_full) begin
            a_cnt_next = a_cnt_reg + CNT_W'(1);
        end
        if (cmd.push_b && !b_full) begin
            b_cnt_next = b_cnt_reg + CNT_W'(1);
        end
        if (cmd.step) begin
            if (take_a) begin
                a_cnt_next = a_cnt_reg - CNT_W'(1);
            end else begin
                b_cnt_next = b_cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_cnt_reg <= '0;
            b_cnt_reg <= '0;
        end else begin
            a_cnt_reg <= a_cnt_next;
            b_cnt_reg <= b_cnt_next;
        end
    end

    // read address follows the next count so the head is ready every cycle
    assign a_rd_addr = (a_cnt_next == '0) ? '0 : ADDR_W'(a_cnt_next - CNT_W'(1));
    assign b_rd_addr = (b_cnt_next == '0) ? '0 : ADDR_W'(b_cnt_next - CNT_W'(1));

    // list a store
    always_ff @(posedge aclk) begin
        if (cmd.push_a && !a_full) begin
            mem_a[a_cnt_reg[ADDR_W-1:0]] <= value;
        end
        a_head_reg <= mem_a[a_rd_addr];
    end

    // list b store
    always_ff @(posedge aclk) begin
        if (cmd.push_b && !b_full) begin
            mem_b[b_cnt_reg[ADDR_W-1:0]] <= value;
        end
        b_head_reg <= mem_b[b_rd_addr];
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.step || cmd.emit_empty) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            out_pos_reg   <= sum_m1[POS_W-1:0];
            out_value_reg <= take_a ? a_head_reg : b_head_reg;
            out_last_reg  <= (sum_m1 == '0);
            out_empty_reg <= 1'b0;
        end else if (cmd.emit_empty) begin
            out_pos_reg   <= '0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b1;
            out_empty_reg <= 1'b1;
        end
    end

    assign status.out_free    = !out_valid_reg || m_tready;
    assign status.last_step   = (sum_m1 == '0);
    assign status.lists_empty = (a_cnt_reg == '0) && (b_cnt_reg == '0);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - VALUE_W - POS_W){1'b0}}, out_value_reg, out_pos_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_empty_reg;

    // counts never pass the list depth
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        a_cnt_reg <= DEPTH_C && b_cnt_reg <= DEPTH_C)
        else $error("list count above depth");

    // the final merge step leaves both lists empty
    merge_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && status.last_step) |=> (a_cnt_reg == '0 && b_cnt_reg == '0))
        else $error("counts not cleared after merge");

    // an empty result always closes its run
    empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("empty result without last");

    // no step is issued with nothing left to merge
    step_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> !status.lists_empty)
        else $error("merge step on empty lists");

endmodule

@@ design/sorted_list_merge.sv @@
`timescale 1ns / 1ps

// Merges two ascending lists of signed 32-bit values. A request with
// s_tuser = 0 or 1 appends s_tdata to list A or B; pushes into a full list
// are dropped. A request with s_tuser = 2 merges both lists from the back
// and streams out one result per element, highest position first, one per
// cycle while m_tready is high; m_tlast marks position 0, ties place the
// B element above the A element, and two empty lists give a single result
// with m_tuser set. Both lists are empty again after a merge. Each list is a
// memory with one write port and one read port, read every cycle at the
// address of its next head. A merge holds off new requests until its last
// result, or the empty result, has been issued.
// Code 3 is accepted and ignored.
module sorted_list_merge #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [slm_pkg::S_DATA_W-1:0] s_tdata,   // value[31:0]
    input  logic [slm_pkg::ACTION_W-1:0] s_tuser,   // action[1:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [slm_pkg::M_DATA_W-1:0] m_tdata,   // position[5:0], value_res[37:6], zero
    output logic                         m_tlast,
    output logic [0:0]                   m_tuser    // empty_res[0]
);
    import slm_pkg::*;

    slm_cmd_t    cmd;
    slm_status_t status;

    slm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    slm_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .value    (s_tdata[VALUE_W-1:0]),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

@@ sim/merge_checker.sv @@
`timescale 1ns / 1ps

// watches both channels, keeps its own copy of the two lists and compares
// every merged result with the oldest one still owed
module merge_checker #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [slm_pkg::S_DATA_W-1:0] s_tdata,   // value[31:0]
    input  logic [slm_pkg::ACTION_W-1:0] s_tuser,   // action[1:0]
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [slm_pkg::M_DATA_W-1:0] m_tdata,   // position[5:0], value_res[37:6], zero
    input  logic                         m_tlast,
    input  logic [0:0]                   m_tuser,   // empty_res[0]
    output int                           fail_count,
    output int                           owed_results
);

    import slm_pkg::*;

    typedef struct {
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               empty;
    } merged_elem_t;

    logic signed [VALUE_W-1:0] shadow_a [LIST_DEPTH];
    logic signed [VALUE_W-1:0] shadow_b [LIST_DEPTH];
    int                        fill_a;
    int                        fill_b;
    merged_elem_t              merged_q [$];

    // merge both lists from the back, b wins a tie so it lands higher
    task automatic predict_merge();
        int           ia;
        int           ib;
        int           slot;
        merged_elem_t elem;
        ia = fill_a;
        ib = fill_b;
        if (ia + ib == 0) begin
            elem.position = '0;
            elem.value    = '0;
            elem.last     = 1'b1;
            elem.empty    = 1'b1;
            merged_q.push_back(elem);
        end else begin
            for (slot = ia + ib - 1; slot >= 0; slot--) begin
                if (ib == 0 || (ia != 0 && shadow_a[ia-1] > shadow_b[ib-1])) begin
                    elem.value = shadow_a[ia-1];
                    ia--;
                end else begin
                    elem.value = shadow_b[ib-1];
                    ib--;
                end
                elem.position = slot[POS_W-1:0];
                elem.last     = (slot == 0);
                elem.empty    = 1'b0;
                merged_q.push_back(elem);
            end
        end
        fill_a = 0;
        fill_b = 0;
    endtask

    task automatic check_result();
        merged_elem_t       want;
        logic [POS_W-1:0]   got_pos;
        logic [VALUE_W-1:0] got_val;
        got_pos = m_tdata[POS_W-1:0];
        got_val = m_tdata[POS_W +: VALUE_W];
        if (merged_q.size() == 0) begin
            if (fail_count < 10)
                $display("%0t: result with nothing owed: pos %0d value %0d last %0b empty %0b",
                         $realtime, got_pos, $signed(got_val), m_tlast, m_tuser[0]);
            fail_count++;
            return;
        end
        want = merged_q.pop_front();
        if (got_pos !== want.position || got_val !== want.value
                || m_tlast !== want.last || m_tuser[0] !== want.empty) begin
            if (fail_count < 10) begin
                $display("%0t: merged result mismatch", $realtime);
                $display("  expected pos %0d value %0d last %0b empty %0b",
                         want.position, $signed(want.value), want.last, want.empty);
                $display("  actual   pos %0d value %0d last %0b empty %0b",
                         got_pos, $signed(got_val), m_tlast, m_tuser[0]);
            end
            fail_count++;
        end
    endtask

    // sample both channels on the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            fill_a = 0;
            fill_b = 0;
            merged_q.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    ACT_PUSH_A: begin
                        if (fill_a < LIST_DEPTH) begin
                            shadow_a[fill_a] = s_tdata;
                            fill_a++;
                        end
                    end
                    ACT_PUSH_B: begin
                        if (fill_b < LIST_DEPTH) begin
                            shadow_b[fill_b] = s_tdata;
                            fill_b++;
                        end
                    end
                    ACT_MERGE: begin
                        predict_merge();
                    end
                    default: ;
                endcase
            end
        end
        owed_results <= merged_q.size();
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import slm_pkg::*;

    localparam int LIST_DEPTH = 32;
    localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
    localparam int HOLD_CYCLES  = 240;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 340;
    localparam int QUIET_FROM   = 290;

    logic                  aclk;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;   // value[31:0]
    logic [ACTION_W-1:0]   s_tuser  = '0;   // action[1:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;         // position[5:0], value_res[37:6], zero
    logic                  m_tlast;
    logic [0:0]            m_tuser;         // empty_res[0]

    int   fail_count;
    int   owed_results;
    logic quiet      = 1'b0;
    logic hold_req   = 1'b0;
    logic hold_taken = 1'b0;
    bit   sender_gappy;
    int   random_items;
    int   rx_idle_left;
    int   rx_calm_left;
    int   rx_roll;

    sorted_list_merge #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    merge_checker #(
        .LIST_DEPTH(LIST_DEPTH)
    ) checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .owed_results(owed_results)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // result side backpressure: short bursts, calm stretches, one long hold
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready     <= 1'b0;
            rx_idle_left <= 0;
            rx_calm_left <= 0;
            hold_taken   <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken   <= 1'b1;
            rx_idle_left <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (rx_idle_left != 0) begin
            rx_idle_left <= rx_idle_left - 1;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (rx_calm_left != 0) begin
                rx_calm_left <= rx_calm_left - 1;
            end else if (!quiet) begin
                rx_roll = $urandom_range(0, 31);
                if (rx_roll < 4)
                    rx_idle_left <= $urandom_range(1, 11);
                else if (rx_roll == 4)
                    rx_calm_left <= $urandom_range(30, 80);
            end
        end
    end

    // give up when nothing moves on either channel for too long
    initial begin : watchdog
        int still_cycles;
        still_cycles = 0;
        while (still_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
                still_cycles = 0;
            else
                still_cycles++;
        end
        $display("[sorted_list_merge] ERROR");
        $finish;
    end

    // offer one request and hold it until taken, then maybe pause
    task automatic send_request(input logic [ACTION_W-1:0] act, input logic [31:0] val);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= val;
        do @(posedge aclk); while (!s_tready);
        if (!quiet && sender_gappy && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    function automatic logic [31:0] draw_value(input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 8) - 32'd4;
            default: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000 + $urandom_range(0, 3);
                    1: return 32'h7fff_ffff - $urandom_range(0, 3);
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
        endcase
    endfunction

    // fill both lists in a random interleave, then merge
    task automatic merge_round(input int len_a, input int len_b);
        logic signed [31:0] vals [0:1][0:39];
        logic signed [31:0] tmp;
        int                 len  [0:1];
        int                 sent [0:1];
        int                 mode;
        int                 side;
        int                 i;
        int                 j;
        bit                 in_order;
        len[0]       = len_a;
        len[1]       = len_b;
        mode         = $urandom_range(0, 2);
        in_order     = ($urandom_range(0, 7) != 0);
        sender_gappy = ($urandom_range(0, 2) != 0);
        for (side = 0; side < 2; side++) begin
            for (i = 0; i < len[side]; i++)
                vals[side][i] = draw_value(mode);
            // most lists ascending, a few left scrambled
            if (in_order) begin
                for (i = 1; i < len[side]; i++) begin
                    tmp = vals[side][i];
                    j   = i - 1;
                    while (j >= 0 && vals[side][j] > tmp) begin
                        vals[side][j+1] = vals[side][j];
                        j--;
                    end
                    vals[side][j+1] = tmp;
                end
            end
        end
        sent[0] = 0;
        sent[1] = 0;
        while (sent[0] < len[0] || sent[1] < len[1]) begin
            if (sent[0] == len[0])
                side = 1;
            else if (sent[1] == len[1])
                side = 0;
            else
                side = $urandom_range(0, 1);
            if ($urandom_range(0, 19) == 0)
                send_request(ACT_RESERVED, $urandom());
            send_request(side ? ACT_PUSH_B : ACT_PUSH_A, vals[side][sent[side]]);
            sent[side]++;
            random_items++;
        end
        send_request(ACT_MERGE, $urandom());
        random_items++;
    endtask

    initial begin : stimulus
        int round;
        int pick;
        random_items = 0;
        sender_gappy = 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // merge of two empty lists
        send_request(ACT_MERGE, 32'h1234_5678);
        // extremes on both sides with ties across lists
        send_request(ACT_PUSH_A, 32'h8000_0000);
        send_request(ACT_PUSH_A, 32'hffff_ffff);
        send_request(ACT_PUSH_B, 32'h8000_0000);
        send_request(ACT_PUSH_A, 32'h0000_0000);
        send_request(ACT_PUSH_B, 32'h0000_0000);
        send_request(ACT_PUSH_A, 32'h7fff_ffff);
        send_request(ACT_PUSH_B, 32'h7fff_ffff);
        send_request(ACT_MERGE, 32'h0);
        // unused code is ignored
        send_request(ACT_RESERVED, 32'hdead_beef);
        // only list a, then only list b
        send_request(ACT_PUSH_A, 32'd5);
        send_request(ACT_PUSH_A, 32'd9);
        send_request(ACT_MERGE, 32'h0);
        send_request(ACT_PUSH_B, 32'hffff_fffb);
        send_request(ACT_MERGE, 32'h0);
        // plain tie, then empty again after a merge
        send_request(ACT_PUSH_B, 32'd7);
        send_request(ACT_PUSH_A, 32'd7);
        send_request(ACT_MERGE, 32'h0);
        send_request(ACT_MERGE, 32'h0);

        // random rounds; one long output hold, a calm tail
        round = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (random_items >= QUIET_FROM)
                quiet <= 1'b1;
            if (round == 3) begin
                hold_req <= 1'b1;
                merge_round(20, 20);
            end else begin
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    merge_round($urandom_range(0, 8), $urandom_range(0, 8));
                else if (pick < 17)
                    merge_round($urandom_range(0, 32), $urandom_range(0, 32));
                else if (pick == 17)
                    merge_round($urandom_range(33, 36), $urandom_range(0, 32));
                else if (pick == 18)
                    merge_round($urandom_range(0, 32), $urandom_range(33, 36));
                else
                    merge_round($urandom_range(33, 36), $urandom_range(33, 36));
            end
            round++;
        end
        s_tvalid <= 1'b0;

        // drain what is owed, then look for stray results
        do @(posedge aclk); while (owed_results != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("[sorted_list_merge] OK");
        else
            $display("[sorted_list_merge] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
design/slm_pkg.sv
design/slm_ctrl.sv
design/slm_datapath.sv
design/sorted_list_merge.sv
sim/merge_checker.sv
sim/tb_top.sv
